FILE: hdl/trwl_pkg.sv
// Shared types, constants and helpers for the tiered window rate limiter.
// No dependencies; trwl_update and the core import this package.
package trwl_pkg;

    localparam int CNT_W    = 32;
    localparam int TIME_W   = 32;
    localparam int STREAK_W = 8;
    localparam int CAP_W    = 16;
    localparam int THR_W    = 8;
    localparam int NTIER    = 3;
    localparam int TIER_AW  = $clog2(NTIER);
    localparam int CFG_IW   = 3;
    localparam int CFG_DW   = 16;

    typedef logic [CNT_W-1:0]    t_cnt;
    typedef logic [TIME_W-1:0]   t_time;
    typedef logic [STREAK_W-1:0] t_streak;
    typedef logic [CAP_W-1:0]    t_cap;
    typedef logic [THR_W-1:0]    t_thr;
    typedef logic [TIER_AW-1:0]  t_slot;

    localparam logic [1:0] TIER_STATIC    = 2'd0;
    localparam logic [1:0] TIER_CHEAP     = 2'd1;
    localparam logic [1:0] TIER_EXPENSIVE = 2'd2;

    localparam t_slot SLOT_STATIC    = t_slot'(0);
    localparam t_slot SLOT_CHEAP     = t_slot'(1);
    localparam t_slot SLOT_EXPENSIVE = t_slot'(2);

    typedef enum logic [1:0] {
        VERDICT_ADMIT   = 2'd0,
        VERDICT_LIMITED = 2'd1,
        VERDICT_PUZZLE  = 2'd2
    } t_verdict;

    typedef enum logic [CFG_IW-1:0] {
        CFG_STATIC_CAP       = 3'd0,
        CFG_CHEAP_CAP        = 3'd1,
        CFG_EXPENSIVE_CAP    = 3'd2,
        CFG_ESCALATE_AFTER   = 3'd3,
        CFG_DEESCALATE_AFTER = 3'd4
    } t_cfg_idx;

    localparam t_cap RST_STATIC_CAP    = t_cap'(400);
    localparam t_cap RST_CHEAP_CAP     = t_cap'(100);
    localparam t_cap RST_EXPENSIVE_CAP = t_cap'(20);
    localparam t_thr RST_ESC_AFTER     = t_thr'(5);
    localparam t_thr RST_DEESC_AFTER   = t_thr'(15);

    // one RAM word per tier
    typedef struct packed {
        t_cnt  count;
        t_time start;
        t_cnt  admitted;
        t_cnt  denied;
    } t_entry;

    typedef struct packed {
        t_cap static_cap;
        t_cap cheap_cap;
        t_cap expensive_cap;
        t_thr esc_after;
        t_thr deesc_after;
    } t_cfg;

    typedef struct packed {
        t_streak sat_streak;
        t_streak clr_streak;
        logic    escalated;
        t_cnt    esc_total;
        t_cnt    deesc_total;
        t_cnt    puz_req_total;
        t_cnt    puz_pass_total;
        t_cnt    puz_fail_total;
    } t_press;

    typedef struct packed {
        logic [31:0] window_count;
        logic        escalated;
        t_verdict    verdict;
    } t_result;

    function automatic t_cnt cnt_inc(input t_cnt v);
        return (v == '1) ? v : v + t_cnt'(1);
    endfunction

    function automatic t_streak streak_inc(input t_streak v);
        return (v == '1) ? v : v + t_streak'(1);
    endfunction

    // unused tier code shares the cheap tier
    function automatic t_slot tier_slot(input logic [1:0] tier);
        t_slot s;
        case (tier)
            TIER_STATIC:    s = SLOT_STATIC;
            TIER_EXPENSIVE: s = SLOT_EXPENSIVE;
            default:        s = SLOT_CHEAP;
        endcase
        return s;
    endfunction

endpackage

FILE: hdl/trwl_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
module trwl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/trwl_update.sv
// Per-request update: window budget, pressure streaks, escalation and verdict.
// Pure logic between the tier RAM read and its write back; uses trwl_pkg.
module trwl_update import trwl_pkg::*; (
    input  t_entry  i_entry,
    input  t_slot   i_slot,
    input  t_time   i_now,
    input  logic    i_puzzle,
    input  t_cfg    i_cfg,
    input  t_press  i_press,
    output t_entry  o_entry,
    output t_press  o_press,
    output t_result o_result
);

    t_cap    cap;
    logic    rollover;
    logic    ok;
    logic    saturated;
    logic    clear;
    logic    track;
    t_streak sat_s;
    t_streak clr_s;
    logic    n_esc;

    always_comb begin
        case (i_slot)
            SLOT_STATIC:    cap = i_cfg.static_cap;
            SLOT_EXPENSIVE: cap = i_cfg.expensive_cap;
            default:        cap = i_cfg.cheap_cap;
        endcase
    end

    always_comb begin
        o_entry  = i_entry;
        rollover = (i_now != i_entry.start);
        if (rollover) begin
            o_entry.start = i_now;
            o_entry.count = t_cnt'(1);
            ok            = 1'b1;
        end else begin
            ok            = (i_entry.count < t_cnt'(cap));
            o_entry.count = cnt_inc(i_entry.count);
        end
        if (ok) begin
            o_entry.admitted = cnt_inc(i_entry.admitted);
        end else begin
            o_entry.denied = cnt_inc(i_entry.denied);
        end
    end

    // streaks and escalation only move on an expensive-window rollover; finished = old count
    always_comb begin
        o_press   = i_press;
        track     = rollover && (i_slot == SLOT_EXPENSIVE);
        saturated = (i_entry.count >= t_cnt'(i_cfg.expensive_cap));
        clear     = (i_entry.count < t_cnt'(i_cfg.expensive_cap >> 1));
        sat_s     = saturated ? streak_inc(i_press.sat_streak) : '0;
        clr_s     = (!saturated && clear) ? streak_inc(i_press.clr_streak) : '0;
        n_esc     = i_press.escalated;
        if (track) begin
            if (!i_press.escalated && (sat_s >= t_streak'(i_cfg.esc_after))) begin
                n_esc             = 1'b1;
                o_press.esc_total = cnt_inc(i_press.esc_total);
                sat_s             = '0;
            end else if (i_press.escalated && (clr_s >= t_streak'(i_cfg.deesc_after))) begin
                n_esc               = 1'b0;
                o_press.deesc_total = cnt_inc(i_press.deesc_total);
                clr_s               = '0;
            end
            o_press.sat_streak = sat_s;
            o_press.clr_streak = clr_s;
        end
        o_press.escalated = n_esc;

        o_result.verdict = ok ? VERDICT_ADMIT : VERDICT_LIMITED;
        if ((i_slot == SLOT_EXPENSIVE) && n_esc) begin
            o_press.puz_req_total = cnt_inc(i_press.puz_req_total);
            if (i_puzzle) begin
                o_press.puz_pass_total = cnt_inc(i_press.puz_pass_total);
                o_result.verdict       = VERDICT_ADMIT;
            end else begin
                o_press.puz_fail_total = cnt_inc(i_press.puz_fail_total);
                o_result.verdict       = VERDICT_PUZZLE;
            end
        end
        o_result.escalated    = n_esc;
        o_result.window_count = 32'(o_entry.count);
    end

endmodule

FILE: hdl/tiered_window_rate_limiter_core.sv
// Tiered fixed-window rate limiter, top level: pipeline, tier RAM, config.
// Uses trwl_pkg, trwl_ram and trwl_update.
//
// Takes one request per clock while the output side is not stalled and
// returns one verdict per request, in order: the first stage reads the
// tier's entry from a three-entry tier RAM (count, window start, admitted
// and denied totals), the second runs the budget and escalation update and
// writes the entry back while the result lands in the output register. A
// request of the same tier right behind takes the written-back entry
// through a bypass, so back-to-back requests never stall on a RAM hazard.
// Per-entry valid bits make the RAM read as zero after reset; there is no
// clearing pass. The configuration port is always ready; write it only
// while no request is in flight.
module tiered_window_rate_limiter_core import trwl_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // request stream
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [31:0]       s_axis_tdata,   // [31:0] now_seconds
    input  logic [2:0]        s_axis_tuser,   // [1:0] tier, [2] puzzle_valid
    // verdict stream
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [39:0]       m_axis_tdata,   // [1:0] verdict, [2] escalated_now,
                                              // [34:3] window_count, [39:35] zero
    // configuration writes
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [CFG_IW-1:0] i_cfg_index,
    input  logic [CFG_DW-1:0] i_cfg_data
);

    localparam int EW = $bits(t_entry);

    logic          s_accept;
    logic          s1_fire;
    t_slot         in_slot;

    logic          r_s1_valid;
    t_slot         r_s1_slot;
    t_time         r_s1_now;
    logic          r_s1_puzzle;
    logic          r_byp;
    t_entry        r_byp_data;
    logic [NTIER-1:0] r_init;
    t_cfg          r_cfg;
    t_press        r_press;
    logic          r_out_valid;
    t_result       r_out;

    logic [EW-1:0] ram_rdata;
    t_entry        cur_entry;
    t_entry        n_entry;
    t_press        n_press;
    t_result       n_result;

    assign s1_fire       = r_s1_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_s1_valid || s1_fire;
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign in_slot       = tier_slot(s_axis_tuser[1:0]);
    assign o_cfg_ready   = 1'b1;

    trwl_ram #(
        .WIDTH (EW),
        .DEPTH (NTIER)
    ) u_tier_ram (
        .i_clk   (i_clk),
        .i_we    (s1_fire),
        .i_waddr (r_s1_slot),
        .i_wdata (n_entry),
        .i_re    (s_accept),
        .i_raddr (in_slot),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        if (r_byp) begin
            cur_entry = r_byp_data;
        end else if (r_init[r_s1_slot]) begin
            cur_entry = t_entry'(ram_rdata);
        end else begin
            cur_entry = '0;
        end
    end

    trwl_update u_update (
        .i_entry  (cur_entry),
        .i_slot   (r_s1_slot),
        .i_now    (r_s1_now),
        .i_puzzle (r_s1_puzzle),
        .i_cfg    (r_cfg),
        .i_press  (r_press),
        .o_entry  (n_entry),
        .o_press  (n_press),
        .o_result (n_result)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_byp       <= 1'b0;
            r_init      <= '0;
            r_press     <= '0;
            r_cfg.static_cap    <= RST_STATIC_CAP;
            r_cfg.cheap_cap     <= RST_CHEAP_CAP;
            r_cfg.expensive_cap <= RST_EXPENSIVE_CAP;
            r_cfg.esc_after     <= RST_ESC_AFTER;
            r_cfg.deesc_after   <= RST_DEESC_AFTER;
        end else begin
            if (s_accept) begin
                r_s1_valid <= 1'b1;
                // entry written this edge is not yet visible at the RAM read port
                r_byp      <= s1_fire && (r_s1_slot == in_slot);
            end else if (s1_fire) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_fire) begin
                r_out_valid         <= 1'b1;
                r_init[r_s1_slot]   <= 1'b1;
                r_press             <= n_press;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_STATIC_CAP:       r_cfg.static_cap    <= t_cap'(i_cfg_data);
                    CFG_CHEAP_CAP:        r_cfg.cheap_cap     <= t_cap'(i_cfg_data);
                    CFG_EXPENSIVE_CAP:    r_cfg.expensive_cap <= t_cap'(i_cfg_data);
                    CFG_ESCALATE_AFTER:   r_cfg.esc_after     <= i_cfg_data[THR_W-1:0];
                    CFG_DEESCALATE_AFTER: r_cfg.deesc_after   <= i_cfg_data[THR_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_s1_slot   <= in_slot;
            r_s1_now    <= TIME_W'(s_axis_tdata);
            r_s1_puzzle <= s_axis_tuser[2];
            r_byp_data  <= n_entry;
        end
        if (s1_fire) begin
            r_out <= n_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'b0, r_out.window_count, r_out.escalated, r_out.verdict};

`ifndef SYNTHESIS
    a_accept_fills_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept |=> r_s1_valid)
        else $error("accepted request did not reach the update stage");

    a_puzzle_needs_escalation: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tdata[1:0] == VERDICT_PUZZLE)) |-> m_axis_tdata[2])
        else $error("puzzle verdict without escalation");

    a_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[34:3] != 32'd0))
        else $error("window count zero after a request");

    a_escalation_moves_on_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s1_fire |=> $stable(r_press.escalated))
        else $error("escalation flag changed without a request");
`endif

endmodule

FILE: dv/tiered_window_rate_limiter_core_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for tiered_window_rate_limiter_core: directed and random request
// traffic with random back-pressure, checked against an in-bench admission predictor.
// Depends on trwl_pkg and the RTL under hdl/.
module tiered_window_rate_limiter_core_tb;
    import trwl_pkg::*;

    localparam int          CYCLE_LIMIT  = 1_000_000;
    localparam int          DRAIN_CYCLES = 4;
    localparam logic [1:0]  TIER_SPARE   = 2'd3;
    localparam logic [CFG_IW-1:0] CFG_IDX_UNUSED = 3'd7;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [31:0]       s_axis_tdata = '0;    // [31:0] now_seconds
    logic [2:0]        s_axis_tuser = '0;    // [1:0] tier, [2] puzzle_valid
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [39:0]       m_axis_tdata;         // [1:0] verdict, [2] escalated_now,
                                             // [34:3] window_count, [39:35] zero
    logic              i_cfg_valid = 1'b0;
    logic              o_cfg_ready;
    logic [CFG_IW-1:0] i_cfg_index = '0;
    logic [CFG_DW-1:0] i_cfg_data = '0;

    tiered_window_rate_limiter_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // ---------------- admission predictor ----------------
    t_cap    cap_static, cap_cheap, cap_exp;
    t_thr    esc_thr, deesc_thr;
    t_cnt    win_count [NTIER];
    t_time   win_start [NTIER];
    t_streak sat_run, clr_run;
    logic    esc_on;

    t_result verdicts_due [$];

    int errors = 0;
    int checked = 0;
    int n_requests = 0;
    int n_reg_writes = 0;
    int n_esc_on = 0;
    int n_esc_off = 0;
    int n_limited = 0;
    int n_puzzle = 0;

    // pacing controls
    bit tx_steady = 1'b0;
    bit rx_steady = 1'b0;
    int rx_hold_req = 0;
    int rx_hold_left = 0;
    int rx_stall_left = 0;
    int unsigned cycles = 0;

    task automatic reset_model();
        cap_static = RST_STATIC_CAP;
        cap_cheap  = RST_CHEAP_CAP;
        cap_exp    = RST_EXPENSIVE_CAP;
        esc_thr    = RST_ESC_AFTER;
        deesc_thr  = RST_DEESC_AFTER;
        for (int i = 0; i < NTIER; i++) begin
            win_count[i] = '0;
            win_start[i] = '0;
        end
        sat_run = '0;
        clr_run = '0;
        esc_on  = 1'b0;
    endtask

    function automatic void apply_reg(input logic [CFG_IW-1:0] idx,
                                      input logic [CFG_DW-1:0] data);
        case (idx)
            CFG_STATIC_CAP:       cap_static = data[CAP_W-1:0];
            CFG_CHEAP_CAP:        cap_cheap  = data[CAP_W-1:0];
            CFG_EXPENSIVE_CAP:    cap_exp    = data[CAP_W-1:0];
            CFG_ESCALATE_AFTER:   esc_thr    = data[THR_W-1:0];
            CFG_DEESCALATE_AFTER: deesc_thr  = data[THR_W-1:0];
            default: ;
        endcase
        n_reg_writes++;
    endfunction

    // finished expensive window feeds the streaks; escalation has hysteresis
    function automatic void close_exp_window(input t_cnt finished);
        logic hit, calm;
        hit  = finished >= t_cnt'(cap_exp);
        calm = finished < t_cnt'(cap_exp >> 1);
        if (hit) begin
            sat_run = (sat_run == '1) ? sat_run : sat_run + 1'b1;
            clr_run = '0;
        end else begin
            sat_run = '0;
            clr_run = !calm ? '0 : (clr_run == '1) ? clr_run : clr_run + 1'b1;
        end
        if (!esc_on && sat_run >= esc_thr) begin
            esc_on  = 1'b1;
            sat_run = '0;
            n_esc_on++;
        end else if (esc_on && clr_run >= deesc_thr) begin
            esc_on  = 1'b0;
            clr_run = '0;
            n_esc_off++;
        end
    endfunction

    function automatic t_result admit_request(input logic [1:0] tier, input t_time now,
                                              input logic puzzle);
        t_slot   slot;
        t_cnt    cap;
        t_cnt    finished;
        logic    ok;
        t_result res;
        case (tier)
            TIER_STATIC:    slot = SLOT_STATIC;
            TIER_EXPENSIVE: slot = SLOT_EXPENSIVE;
            default:        slot = SLOT_CHEAP;
        endcase
        case (slot)
            SLOT_STATIC:    cap = t_cnt'(cap_static);
            SLOT_EXPENSIVE: cap = t_cnt'(cap_exp);
            default:        cap = t_cnt'(cap_cheap);
        endcase
        if (now != win_start[slot]) begin
            finished        = win_count[slot];
            win_start[slot] = now;
            win_count[slot] = t_cnt'(1);
            if (slot == SLOT_EXPENSIVE)
                close_exp_window(finished);
            ok = 1'b1;
        end else begin
            ok = win_count[slot] < cap;
            if (win_count[slot] != '1)
                win_count[slot] = win_count[slot] + 1'b1;
        end
        res.verdict = ok ? VERDICT_ADMIT : VERDICT_LIMITED;
        // escalated expensive tier: puzzle decides, budget verdict dropped
        if (slot == SLOT_EXPENSIVE && esc_on)
            res.verdict = puzzle ? VERDICT_ADMIT : VERDICT_PUZZLE;
        res.escalated    = esc_on;
        res.window_count = win_count[slot];
        if (res.verdict == VERDICT_LIMITED) n_limited++;
        if (res.verdict == VERDICT_PUZZLE)  n_puzzle++;
        n_requests++;
        return res;
    endfunction

    // track accepted transfers on the request and config channels
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready)
                apply_reg(i_cfg_index, i_cfg_data);
            if (s_axis_tvalid && s_axis_tready)
                verdicts_due.push_back(admit_request(s_axis_tuser[1:0], s_axis_tdata,
                                                     s_axis_tuser[2]));
        end
    end

    // ---------------- verdict checker ----------------
    always @(posedge i_clk) begin : verdict_check
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (verdicts_due.size() == 0) begin
                $display("%0t: verdict transfer with nothing expected, data %h",
                         $time, m_axis_tdata);
                errors++;
            end else begin
                want = verdicts_due.pop_front();
                checked++;
                if (m_axis_tdata[1:0] !== want.verdict) begin
                    $display("%0t: verdict expected %0d actual %0d", $time,
                             want.verdict, m_axis_tdata[1:0]);
                    errors++;
                end
                if (m_axis_tdata[2] !== want.escalated) begin
                    $display("%0t: escalated_now expected %0d actual %0d", $time,
                             want.escalated, m_axis_tdata[2]);
                    errors++;
                end
                if (m_axis_tdata[34:3] !== want.window_count) begin
                    $display("%0t: window_count expected %0d actual %0d", $time,
                             want.window_count, m_axis_tdata[34:3]);
                    errors++;
                end
                if (m_axis_tdata[39:35] !== 5'd0) begin
                    $display("%0t: pad bits expected 0 actual %h", $time,
                             m_axis_tdata[39:35]);
                    errors++;
                end
            end
        end
    end

    // ---------------- pacing ----------------
    // mostly no gap, some short ones, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(12, 40);
    endfunction

    always @(posedge i_clk) begin : rx_pace
        int stall;
        if (rx_hold_left > 0) begin
            m_axis_tready <= 1'b0;
            rx_hold_left  <= rx_hold_left - 1;
        end else if (rx_hold_req > 0) begin
            m_axis_tready <= 1'b0;
            rx_hold_left  <= rx_hold_req - 1;
            rx_hold_req   <= 0;
        end else if (rx_stall_left > 0) begin
            m_axis_tready <= 1'b0;
            rx_stall_left <= rx_stall_left - 1;
        end else if (rx_steady) begin
            m_axis_tready <= 1'b1;
        end else begin
            stall = pick_gap();
            m_axis_tready <= (stall == 0);
            if (stall > 0)
                rx_stall_left <= stall - 1;
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("%0t: run timed out after %0d cycles, %0d verdicts outstanding",
                     $time, cycles, verdicts_due.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // ---------------- shared drivers ----------------
    task automatic send_request(input logic [1:0] tier, input t_time now,
                                input logic puzzle);
        int gap;
        gap = tx_steady ? 0 : pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= now;
        s_axis_tuser  <= {puzzle, tier};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // stop offering and wait until every verdict is back
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (verdicts_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [CFG_DW-1:0] data);
        wait_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [1:0] pick_tier();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return TIER_EXPENSIVE;
        if (r < 70) return TIER_STATIC;
        if (r < 90) return TIER_CHEAP;
        return TIER_SPARE;
    endfunction

    function automatic logic [CFG_DW-1:0] pick_cap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 85) return CFG_DW'($urandom_range(1, 8));
        if (r < 95) return CFG_DW'($urandom_range(0, 65535));
        return '1;
    endfunction

    // upper byte is junk; only the low byte lands in a threshold
    function automatic logic [CFG_DW-1:0] pick_thr();
        logic [7:0] thr;
        thr = ($urandom_range(0, 99) < 80) ? 8'($urandom_range(0, 4)) : 8'($urandom);
        return {8'($urandom), thr};
    endfunction

    // ---------------- tests ----------------
    // second 0 right after reset lands in the reset window, no rollover
    task automatic test_reset_window();
        send_request(TIER_STATIC, 32'd0, 1'b0);
        send_request(TIER_CHEAP, 32'd0, 1'b0);
        send_request(TIER_SPARE, 32'd0, 1'b1);
        send_request(TIER_EXPENSIVE, 32'd0, 1'b0);
        send_request(TIER_EXPENSIVE, 32'd0, 1'b1);
    endtask

    task automatic test_tier_codes();
        send_request(TIER_STATIC, 32'hFFFF_FFFF, 1'b1);
        send_request(TIER_CHEAP, 32'hFFFF_FFFF, 1'b0);
        send_request(TIER_SPARE, 32'hFFFF_FFFF, 1'b1);
        send_request(TIER_EXPENSIVE, 32'hFFFF_FFFF, 1'b1);
        send_request(TIER_SPARE, 32'h5555_5555, 1'b0);
        send_request(TIER_CHEAP, 32'hAAAA_AAAA, 1'b1);
        send_request(TIER_EXPENSIVE, 32'hAAAA_AAAA, 1'b0);
    endtask

    // zero static and expensive caps, full cheap cap, zero thresholds: escalation flips on every expensive rollover
    task automatic test_cap_extremes();
        write_reg(CFG_STATIC_CAP, 16'd0);
        write_reg(CFG_CHEAP_CAP, 16'hFFFF);
        write_reg(CFG_EXPENSIVE_CAP, 16'd0);
        write_reg(CFG_ESCALATE_AFTER, 16'hFF00);
        write_reg(CFG_DEESCALATE_AFTER, 16'h5A00);
        write_reg(CFG_IDX_UNUSED, 16'hFFFF);
        send_request(TIER_STATIC, 32'd7, 1'b0);
        send_request(TIER_STATIC, 32'd7, 1'b0);
        send_request(TIER_CHEAP, 32'd7, 1'b0);
        send_request(TIER_CHEAP, 32'd7, 1'b1);
        send_request(TIER_EXPENSIVE, 32'd7, 1'b0);
        send_request(TIER_EXPENSIVE, 32'd7, 1'b1);
        send_request(TIER_EXPENSIVE, 32'd8, 1'b0);
        send_request(TIER_EXPENSIVE, 32'd8, 1'b0);
        send_request(TIER_EXPENSIVE, 32'd9, 1'b0);
        send_request(TIER_EXPENSIVE, 32'd9, 1'b1);
    endtask

    // long output hold-off while the sender keeps pushing, then a full drain
    task automatic test_output_stall();
        t_time sec;
        write_reg(CFG_EXPENSIVE_CAP, 16'd6);
        write_reg(CFG_CHEAP_CAP, 16'd3);
        sec = $urandom();
        tx_steady = 1'b1;
        rx_hold_req <= 300;
        repeat (40) send_request(pick_tier(), sec, 1'($urandom));
        tx_steady = 1'b0;
        wait_idle();
        repeat (20) send_request(pick_tier(), sec + 1, 1'($urandom));
    endtask

    // thresholds at 255: streaks must count all the way up
    task automatic test_streak_extremes();
        t_time sec;
        write_reg(CFG_EXPENSIVE_CAP, 16'd1);
        write_reg(CFG_ESCALATE_AFTER, 16'hA5FF);
        write_reg(CFG_DEESCALATE_AFTER, 16'h00FF);
        sec = $urandom();
        repeat (300) begin
            sec++;
            send_request(TIER_EXPENSIVE, sec, 1'($urandom));
        end
        // single-request windows stay under half of 4, so clear windows pile up
        write_reg(CFG_EXPENSIVE_CAP, 16'd4);
        repeat (300) begin
            sec++;
            send_request(TIER_EXPENSIVE, sec, 1'($urandom));
        end
    endtask

    task automatic test_random_traffic(input int phases, input int per_phase);
        t_time sec;
        int    sent;
        int    burst;
        int    lim;
        int    r;
        for (int p = 0; p < phases; p++) begin
            write_reg(CFG_STATIC_CAP, pick_cap());
            write_reg(CFG_CHEAP_CAP, pick_cap());
            write_reg(CFG_EXPENSIVE_CAP, pick_cap());
            write_reg(CFG_ESCALATE_AFTER, pick_thr());
            write_reg(CFG_DEESCALATE_AFTER, pick_thr());
            if ($urandom_range(0, 3) == 0)
                write_reg(CFG_IDX_UNUSED - 3'($urandom_range(0, 2)), 16'($urandom));
            tx_steady = ($urandom_range(0, 3) == 0);
            rx_steady = ($urandom_range(0, 3) == 0);
            sec  = $urandom();
            sent = 0;
            while (sent < per_phase) begin
                // one second's burst, sized around the expensive budget
                lim   = (cap_exp > 12) ? 12 : int'(cap_exp);
                burst = $urandom_range(1, 3 * lim + 3);
                repeat (burst) send_request(pick_tier(), sec, 1'($urandom));
                sent += burst;
                r = $urandom_range(0, 99);
                if (r < 80)      sec = sec + 1;
                else if (r < 90) sec = sec + t_time'($urandom_range(2, 5));
                else if (r < 95) sec = sec - t_time'($urandom_range(1, 3));
                else             sec = $urandom();
            end
        end
        tx_steady = 1'b0;
        rx_steady = 1'b0;
    endtask

    initial begin
        reset_model();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_window();
        test_tier_codes();
        test_cap_extremes();
        test_output_stall();
        test_streak_extremes();
        test_random_traffic(6, 100);

        wait_idle();
        repeat (4 * DRAIN_CYCLES) @(posedge i_clk);
        if (verdicts_due.size() != 0) begin
            $display("%0t: %0d verdicts never arrived", $time, verdicts_due.size());
            errors += verdicts_due.size();
        end

        $display("Checked %0d verdicts for %0d requests across %0d register writes.",
                 checked, n_requests, n_reg_writes);
        $display("Escalation on %0d / off %0d times; %0d rate limited, %0d puzzle demands.",
                 n_esc_on, n_esc_off, n_limited, n_puzzle);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
